// ----- design/ows_pkg.sv -----
// Shared types and constants for the single-wire ROM search unit.
// Holds the beat payload structs, action codes and status codes; no dependencies.
package ows_pkg;

	// Action codes carried by an input beat.
	localparam logic [1:0] ACT_RESET = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_PAIR  = 2'd2;

	// Status codes reported with each result beat.
	localparam logic [1:0] ST_CONT    = 2'd0;
	localparam logic [1:0] ST_FOUND   = 2'd1;
	localparam logic [1:0] ST_FAIL    = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	// Positions below this limit lie within the family byte.
	localparam int FAMILY_LIMIT = 9;
	localparam int FAM_W        = 4;
	localparam int FAMILY_W     = 7;
	localparam int ROM_VALUE_W  = 64;
	localparam int COUNT_W      = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	typedef struct packed {
		logic [1:0] action;
		logic       presence;
		logic       true_bit;
		logic       complement_bit;
	} item_t;

	typedef struct packed {
		logic                   send_valid;
		logic                   direction_bit;
		logic [1:0]             status;
		logic [ROM_VALUE_W-1:0] rom_value;
		logic [COUNT_W-1:0]     device_count;
		logic                   last_device;
		logic [FAMILY_W-1:0]    family_discrepancy;
	} result_t;

endpackage

// ----- design/onewire_rom_search_unit.sv -----
// A beat moves from the input register through the decision into the result register.
// Throughput: one beat per cycle when the result register is free; the decision is one
// short path from input to result register, and the search state updates in that cycle.
// Reset (arst_n low, asynchronous) clears the ROM register, marks, flags, counter
// and both pipeline valid bits; the bit position returns to one.
// Top level of the ROM search decision engine; depends on ows_pkg.
module onewire_rom_search_unit #(
	parameter int ROM_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ows_pkg::item_t   item,
	output logic             res_valid,
	input  logic             res_ready,
	output ows_pkg::result_t res
);
	import ows_pkg::*;

	localparam int POS_W = $clog2(ROM_BITS + 2);
	localparam int IDX_W = $clog2(ROM_BITS);
	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(ROM_BITS);
	localparam logic [POS_W-1:0] POS_FAM   = POS_W'(FAMILY_LIMIT);

	// Pipeline registers.
	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;

	// Search state.
	logic [ROM_BITS-1:0] rom_q,    rom_d;
	logic [POS_W-1:0]    pos_q,    pos_d;
	logic                active_q, active_d;
	logic [POS_W-1:0]    zmark_q,  zmark_d;
	logic [POS_W-1:0]    ldm_q,    ldm_d;
	logic [FAM_W-1:0]    fam_q,    fam_d;
	logic                final_q,  final_d;
	logic [COUNT_W-1:0]  count_q,  count_d;

	logic       advance;
	logic       fire;
	logic       send;
	logic       dir;
	logic [1:0] status;
	logic [IDX_W-1:0] idx;

	// The result register frees up when empty or when its beat is taken.
	assign advance    = !res_valid_q || res_ready;
	assign fire       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign idx        = IDX_W'(pos_q - POS_FIRST);

	// Decision for the beat held in the input register.
	always_comb begin
		rom_d    = rom_q;
		pos_d    = pos_q;
		active_d = active_q;
		zmark_d  = zmark_q;
		ldm_d    = ldm_q;
		fam_d    = fam_q;
		final_d  = final_q;
		count_d  = count_q;
		send     = 1'b0;
		dir      = 1'b0;
		status   = ST_CONT;
		case (item_s1.action)
			ACT_RESET: begin
				ldm_d    = '0;
				fam_d    = '0;
				final_d  = 1'b0;
				active_d = 1'b0;
				count_d  = '0;
				pos_d    = POS_FIRST;
				zmark_d  = '0;
			end
			ACT_START: begin
				if (final_q || !item_s1.presence) begin
					ldm_d    = '0;
					fam_d    = '0;
					final_d  = 1'b0;
					active_d = 1'b0;
					status   = ST_FAIL;
				end else begin
					active_d = 1'b1;
					pos_d    = POS_FIRST;
					zmark_d  = '0;
				end
			end
			ACT_PAIR: begin
				if (!active_q) begin
					status = ST_IGNORED;
				end else if (item_s1.true_bit && item_s1.complement_bit) begin
					// No device answered this position.
					ldm_d    = '0;
					fam_d    = '0;
					final_d  = 1'b0;
					active_d = 1'b0;
					status   = ST_FAIL;
				end else begin
					if (item_s1.true_bit != item_s1.complement_bit) begin
						dir = item_s1.true_bit;
					end else begin
						// Discrepancy: follow the previous ROM below the last mark, 1 at it, 0 above it.
						if (pos_q < ldm_q) begin
							dir = rom_q[idx];
						end else begin
							dir = (pos_q == ldm_q);
						end
						if (!dir) begin
							zmark_d = pos_q;
							if (pos_q < POS_FAM) begin
								fam_d = FAM_W'(pos_q);
							end
						end
					end
					rom_d[idx] = dir;
					send       = 1'b1;
					pos_d      = pos_q + POS_W'(1);
					// Close the pass after the last ROM bit.
					if (pos_q == POS_LAST) begin
						active_d = 1'b0;
						pos_d    = POS_FIRST;
						ldm_d    = zmark_d;
						if (zmark_d == '0) begin
							final_d = 1'b1;
						end
						if (rom_d[7:0] == 8'd0) begin
							ldm_d    = '0;
							fam_d    = '0;
							final_d  = 1'b0;
							active_d = 1'b0;
							status   = ST_FAIL;
						end else begin
							if (count_q != COUNT_MAX) begin
								count_d = count_q + COUNT_W'(1);
							end
							status = ST_FOUND;
						end
					end
				end
			end
			default: begin
				status = ST_IGNORED;
			end
		endcase
	end

	// Control registers: valid bits and search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			rom_q       <= '0;
			pos_q       <= POS_FIRST;
			active_q    <= 1'b0;
			zmark_q     <= '0;
			ldm_q       <= '0;
			fam_q       <= '0;
			final_q     <= 1'b0;
			count_q     <= '0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (fire) begin
				rom_q    <= rom_d;
				pos_q    <= pos_d;
				active_q <= active_d;
				zmark_q  <= zmark_d;
				ldm_q    <= ldm_d;
				fam_q    <= fam_d;
				final_q  <= final_d;
				count_q  <= count_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (fire) begin
			res_q.send_valid         <= send;
			res_q.direction_bit      <= dir;
			res_q.status             <= status;
			res_q.rom_value          <= ROM_VALUE_W'(rom_d);
			res_q.device_count       <= count_d;
			res_q.last_device        <= final_d;
			res_q.family_discrepancy <= FAMILY_W'(fam_d);
		end
	end

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (pos_q >= POS_FIRST && pos_q <= POS_LAST))
		else $error("bit position out of range during a pass");

	a_fam_range: assert property (@(posedge clk) disable iff (!arst_n)
		fam_q < FAM_W'(FAMILY_LIMIT))
		else $error("family mark beyond the family byte");

	a_found_family: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status == ST_FOUND) |-> (res_q.rom_value[7:0] != 8'd0))
		else $error("device reported with a zero family byte");

	a_nosend_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.send_valid) |-> !res_q.direction_bit)
		else $error("direction bit set without a send");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !item_ready)
		else $error("input taken while the held beat is stalled");
`endif

endmodule
